/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge outside reset.
`define IAP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("iap assertion failed");

// Checked at every rising edge, reset included.
`define IAP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("iap assertion failed");

`else

`define IAP_ASSERT(lbl, clk, rst, prop)
`define IAP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hdl/iap_pkg.sv */
package iap_pkg;

  localparam int COUNT_WIDTH = 32;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_ATOM   = 4'd1,
    MODE_QUOTE  = 4'd2,
    MODE_QESC   = 4'd3,
    MODE_QCLOSE = 4'd4,
    MODE_LDIGIT = 4'd5,
    MODE_LCR    = 4'd6,
    MODE_LLF    = 4'd7,
    MODE_LDATA  = 4'd8,
    MODE_LSTOP  = 4'd9
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One result item.
  typedef struct packed {
    logic       syntax_error;
    logic [7:0] stop_byte;
    logic       token_done;
    logic       content_valid;
    logic [7:0] content_byte;
  } res_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic ends_atom(input logic [7:0] c);
    return (c == CH_NUL) || is_white(c) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_DQUOTE);
  endfunction

endpackage

/* hdl/iap_parse_core.sv */
`include "assert_macros.svh"

module iap_parse_core
  import iap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       start_req,
  output res_t       res
);

  mode_t                  mode;
  mode_t                  mode_next;
  logic                   saw_digit;
  logic                   saw_digit_next;
  logic [COUNT_WIDTH-1:0] remaining;
  logic [COUNT_WIDTH-1:0] remaining_next;

  logic                   is_digit;
  logic [3:0]             digit;
  logic [COUNT_WIDTH+3:0] count_wide;
  logic                   count_ovf;
  logic [COUNT_WIDTH-1:0] remaining_dec;
  logic                   bad_first;

  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit     = 4'(in_byte - CH_ZERO);
  // remaining * 10 + digit, with four guard bits to see an overflow.
  assign count_wide = ({4'd0, remaining} << 3) + ({4'd0, remaining} << 1) +
                      (COUNT_WIDTH + 4)'(digit);
  assign count_ovf  = (count_wide[COUNT_WIDTH+3:COUNT_WIDTH] != 4'd0);
  assign remaining_dec = remaining - COUNT_WIDTH'(1);
  assign bad_first = (in_byte == CH_NUL) || (in_byte == CH_SPACE) ||
                     (in_byte == CH_LPAREN) || (in_byte == CH_RPAREN) ||
                     (in_byte == CH_CR) || (in_byte == CH_LF);

  // Next state.
  always_comb begin
    mode_next      = mode;
    saw_digit_next = saw_digit;
    remaining_next = remaining;
    if (start_req) begin
      saw_digit_next = 1'b0;
      remaining_next = '0;
      if (bad_first) begin
        mode_next = MODE_IDLE;
      end else if (in_byte == CH_DQUOTE) begin
        mode_next = MODE_QUOTE;
      end else if (in_byte == CH_LBRACE) begin
        mode_next = MODE_LDIGIT;
      end else if (ends_atom(in_byte)) begin
        mode_next = MODE_IDLE;
      end else begin
        mode_next = MODE_ATOM;
      end
    end else begin
      unique case (mode)
        MODE_ATOM: begin
          if (ends_atom(in_byte)) mode_next = MODE_IDLE;
        end
        MODE_QUOTE: begin
          priority if (in_byte == CH_BSLASH) mode_next = MODE_QESC;
          else if (in_byte == CH_DQUOTE) mode_next = MODE_QCLOSE;
          else if ((in_byte == CH_NUL) || (in_byte == CH_CR) || (in_byte == CH_LF))
            mode_next = MODE_IDLE;
          else mode_next = MODE_QUOTE;
        end
        MODE_QESC: mode_next = MODE_QUOTE;
        MODE_QCLOSE, MODE_LSTOP: mode_next = MODE_IDLE;
        MODE_LDIGIT: begin
          priority if (is_digit) begin
            if (count_ovf) begin
              mode_next = MODE_IDLE;
            end else begin
              remaining_next = count_wide[COUNT_WIDTH-1:0];
              saw_digit_next = 1'b1;
            end
          end else if ((in_byte == CH_RBRACE) && saw_digit) begin
            mode_next = MODE_LCR;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_LCR: mode_next = (in_byte == CH_CR) ? MODE_LLF : MODE_IDLE;
        MODE_LLF: begin
          if (in_byte == CH_LF)
            mode_next = (remaining != '0) ? MODE_LDATA : MODE_LSTOP;
          else
            mode_next = MODE_IDLE;
        end
        MODE_LDATA: begin
          remaining_next = remaining_dec;
          if (remaining_dec == '0) mode_next = MODE_LSTOP;
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
    if (mode_next == MODE_IDLE) begin
      saw_digit_next = 1'b0;
      remaining_next = '0;
    end
  end

  // Result fields.
  always_comb begin
    res = '0;
    if (start_req) begin
      if (bad_first) begin
        res.syntax_error = 1'b1;
      end else if ((in_byte == CH_DQUOTE) || (in_byte == CH_LBRACE)) begin
        res = '0;
      end else if (ends_atom(in_byte)) begin
        res.token_done = 1'b1;
        res.stop_byte  = in_byte;
      end else begin
        res.content_valid = 1'b1;
        res.content_byte  = in_byte;
      end
    end else begin
      unique case (mode)
        MODE_ATOM: begin
          if (ends_atom(in_byte)) begin
            res.token_done = 1'b1;
            res.stop_byte  = in_byte;
          end else begin
            res.content_valid = 1'b1;
            res.content_byte  = in_byte;
          end
        end
        MODE_QUOTE: begin
          priority if ((in_byte == CH_BSLASH) || (in_byte == CH_DQUOTE)) begin
            res = '0;
          end else if ((in_byte == CH_NUL) || (in_byte == CH_CR) ||
                       (in_byte == CH_LF)) begin
            res.syntax_error = 1'b1;
          end else begin
            res.content_valid = 1'b1;
            res.content_byte  = in_byte;
          end
        end
        MODE_QESC, MODE_LDATA: begin
          res.content_valid = 1'b1;
          res.content_byte  = in_byte;
        end
        MODE_QCLOSE, MODE_LSTOP: begin
          res.token_done = 1'b1;
          res.stop_byte  = in_byte;
        end
        MODE_LDIGIT: begin
          if (is_digit) res.syntax_error = count_ovf;
          else res.syntax_error = !((in_byte == CH_RBRACE) && saw_digit);
        end
        MODE_LCR: res.syntax_error = (in_byte != CH_CR);
        MODE_LLF: res.syntax_error = (in_byte != CH_LF);
        default: res = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      saw_digit <= 1'b0;
      remaining <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      saw_digit <= saw_digit_next;
      remaining <= remaining_next;
    end
  end

  `IAP_ASSERT_ALWAYS(a_idle_clear, clk,
    (mode == MODE_IDLE) |-> ((remaining == '0) && !saw_digit))
  `IAP_ASSERT(a_ldata_count, clk, rst, (mode == MODE_LDATA) |-> (remaining != '0))
  `IAP_ASSERT(a_header_digit, clk, rst,
    ((mode == MODE_LCR) || (mode == MODE_LLF)) |-> saw_digit)

endmodule

/* hdl/iap_out_buf.sv */
`include "assert_macros.svh"

module iap_out_buf
  import iap_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;
  logic in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
        if (in_fire) out_data <= in_data;
      end
    end else if (in_fire) begin
      // Output is stalled: park the new item in the skid stage.
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

  `IAP_ASSERT_ALWAYS(a_skid_behind_out, clk, skid_valid |-> out_valid)
  `IAP_ASSERT(a_stall_parks, clk, rst,
    (in_fire && out_valid && !out_ready) |=> skid_valid)
  `IAP_ASSERT(a_held_item_kept, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))

endmodule

/* hdl/imap_astring_parser.sv */
// IMAP astring parser, one text byte per item.
// Input channel s_*: tdata carries the byte, tuser marks the first byte of a
// new astring and aborts any token in progress. Every accepted item gives
// exactly one result item on the m_* channel: a content byte, the end of the
// token with the byte that follows it, a syntax error, or an item with all
// fields zero, which is what bytes give while no astring is open. Each result
// is registered in the output buffer. Throughput is one item per cycle while
// s_tready is high; the parse state (mode, literal header flag and a 32-bit
// literal byte counter) updates in a single step per byte, the widest path
// being the count times ten plus digit.
// A two-entry output buffer lets s_tready stay high while one result waits;
// if the receiver holds m_tready low for a second item, s_tready drops and
// rises again in the cycle after the receiver takes the item at the head of
// the buffer. Results are never dropped or reordered.
// Reset (rst, synchronous, active high) empties the buffer and returns the
// parser to idle with the count cleared.
module imap_astring_parser
  import iap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tuser,  // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [7:0] content_byte, [15:8] stop_byte
  output logic [2:0]  m_tuser   // [0] content_valid, [1] token_done, [2] syntax_error
);

  res_t core_res;
  res_t out_res;
  logic accept;

  assign accept = s_tvalid && s_tready;

  iap_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .start_req (s_tuser),
    .res       (core_res)
  );

  iap_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (core_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.stop_byte, out_res.content_byte};
  assign m_tuser = {out_res.syntax_error, out_res.token_done, out_res.content_valid};

endmodule

/* tb/astring_parse_checker.sv */
`timescale 1ns / 1ps

module astring_parse_checker
  import iap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tuser,  // [0] start_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,  // [7:0] content_byte, [15:8] stop_byte
  input  logic [2:0]  m_tuser,  // [0] content_valid, [1] token_done, [2] syntax_error
  output int          mismatches,
  output int          outstanding
);

  mode_t                  mode;
  logic                   digit_seen;
  logic [COUNT_WIDTH-1:0] bytes_left;
  res_t                   awaited_results[$];
  res_t                   seen;
  res_t                   want;

  function automatic logic breaks_atom(input logic [7:0] c);
    return c inside {CH_NUL, CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
                     CH_LPAREN, CH_RPAREN, CH_DQUOTE};
  endfunction

  // Advances the parse state by one byte and returns the result it gives.
  function automatic res_t parse_next_byte(input logic [7:0] c, input logic opening);
    res_t                 r;
    logic [COUNT_WIDTH+4:0] grown;
    r = '0;
    if (opening) begin
      digit_seen = 1'b0;
      bytes_left = '0;
      if (c inside {CH_NUL, CH_SPACE, CH_LPAREN, CH_RPAREN, CH_CR, CH_LF}) begin
        r.syntax_error = 1'b1;
        mode = MODE_IDLE;
      end else if (c == CH_DQUOTE) begin
        mode = MODE_QUOTE;
      end else if (c == CH_LBRACE) begin
        mode = MODE_LDIGIT;
      end else if (breaks_atom(c)) begin
        r.token_done = 1'b1;
        r.stop_byte = c;
        mode = MODE_IDLE;
      end else begin
        r.content_byte = c;
        r.content_valid = 1'b1;
        mode = MODE_ATOM;
      end
    end else begin
      case (mode)
        MODE_ATOM: begin
          if (breaks_atom(c)) begin
            r.token_done = 1'b1;
            r.stop_byte = c;
            mode = MODE_IDLE;
          end else begin
            r.content_byte = c;
            r.content_valid = 1'b1;
          end
        end
        MODE_QUOTE: begin
          if (c == CH_BSLASH) begin
            mode = MODE_QESC;
          end else if (c == CH_DQUOTE) begin
            mode = MODE_QCLOSE;
          end else if (c inside {CH_NUL, CH_CR, CH_LF}) begin
            r.syntax_error = 1'b1;
            mode = MODE_IDLE;
          end else begin
            r.content_byte = c;
            r.content_valid = 1'b1;
          end
        end
        MODE_QESC: begin
          r.content_byte = c;
          r.content_valid = 1'b1;
          mode = MODE_QUOTE;
        end
        MODE_QCLOSE, MODE_LSTOP: begin
          r.token_done = 1'b1;
          r.stop_byte = c;
          mode = MODE_IDLE;
        end
        MODE_LDIGIT: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            grown = bytes_left * 10 + (c - CH_ZERO);
            // Anything spilling above the counter width is an overflow.
            if (grown[COUNT_WIDTH+4:COUNT_WIDTH] != '0) begin
              r.syntax_error = 1'b1;
              mode = MODE_IDLE;
            end else begin
              bytes_left = grown[COUNT_WIDTH-1:0];
              digit_seen = 1'b1;
            end
          end else if (c == CH_RBRACE && digit_seen) begin
            mode = MODE_LCR;
          end else begin
            r.syntax_error = 1'b1;
            mode = MODE_IDLE;
          end
        end
        MODE_LCR: begin
          if (c == CH_CR) begin
            mode = MODE_LLF;
          end else begin
            r.syntax_error = 1'b1;
            mode = MODE_IDLE;
          end
        end
        MODE_LLF: begin
          if (c == CH_LF) begin
            mode = (bytes_left != '0) ? MODE_LDATA : MODE_LSTOP;
          end else begin
            r.syntax_error = 1'b1;
            mode = MODE_IDLE;
          end
        end
        MODE_LDATA: begin
          r.content_byte = c;
          r.content_valid = 1'b1;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) mode = MODE_LSTOP;
        end
        default: begin
          mode = MODE_IDLE;
        end
      endcase
    end
    if (mode == MODE_IDLE) begin
      digit_seen = 1'b0;
      bytes_left = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mode = MODE_IDLE;
      digit_seen = 1'b0;
      bytes_left = '0;
      awaited_results.delete();
    end else begin
      // The result leaving now belongs to an earlier item, so it is checked
      // before the item accepted at this edge is predicted.
      if (m_tvalid && m_tready) begin
        seen.content_byte  = m_tdata[7:0];
        seen.stop_byte     = m_tdata[15:8];
        seen.content_valid = m_tuser[0];
        seen.token_done    = m_tuser[1];
        seen.syntax_error  = m_tuser[2];
        if (awaited_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected result item, valid=%0b byte=%02h done=%0b stop=%02h err=%0b",
                     $realtime, seen.content_valid, seen.content_byte, seen.token_done,
                     seen.stop_byte, seen.syntax_error);
        end else begin
          want = awaited_results.pop_front();
          if (seen.content_byte !== want.content_byte ||
              seen.content_valid !== want.content_valid ||
              seen.token_done !== want.token_done ||
              seen.stop_byte !== want.stop_byte ||
              seen.syntax_error !== want.syntax_error) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected valid=%0b byte=%02h done=%0b stop=%02h err=%0b",
                       want.content_valid, want.content_byte, want.token_done,
                       want.stop_byte, want.syntax_error);
              $display("  actual   valid=%0b byte=%02h done=%0b stop=%02h err=%0b",
                       seen.content_valid, seen.content_byte, seen.token_done,
                       seen.stop_byte, seen.syntax_error);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(parse_next_byte(s_tdata, s_tuser));
    end
    outstanding = awaited_results.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import iap_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;

  int mismatches;
  int outstanding;
  int send_idle_pct = 11;
  int recv_idle_pct = 72;
  int items_sent = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  imap_astring_parser u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  astring_parse_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Receiver: random back-pressure, with a long hold whenever one is asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done = holds_done + 1;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item from a falling edge and returns at the falling edge after
  // it was taken. Ignored bytes are not counted.
  task automatic put_byte(input logic [7:0] b, input logic opening, input bit counted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= opening;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent = items_sent + 1;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] atom_byte(input bit opening);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c inside {CH_NUL, CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
                         CH_LPAREN, CH_RPAREN, CH_DQUOTE} ||
               (opening && c == CH_LBRACE));
    return c;
  endfunction

  function automatic logic [7:0] atom_terminator();
    case ($urandom_range(0, 9))
      0: return CH_NUL;
      1: return CH_SPACE;
      2: return CH_TAB;
      3: return CH_LF;
      4: return CH_VT;
      5: return CH_FF;
      6: return CH_CR;
      7: return CH_LPAREN;
      8: return CH_RPAREN;
      default: return CH_DQUOTE;
    endcase
  endfunction

  function automatic logic [7:0] any_byte_except(input logic [7:0] banned);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == banned);
    return c;
  endfunction

  task automatic send_atom();
    int len;
    len = $urandom_range(0, 8);
    put_byte(atom_byte(1'b1), 1'b1, 1'b1);
    repeat (len) put_byte(atom_byte(1'b0), 1'b0, 1'b1);
    // Now and then the atom is left open and the next astring aborts it.
    if ($urandom_range(0, 9) != 0) put_byte(atom_terminator(), 1'b0, 1'b1);
  endtask

  task automatic send_quoted();
    int len;
    int pick;
    logic [7:0] c;
    len = $urandom_range(0, 10);
    put_byte(CH_DQUOTE, 1'b1, 1'b1);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        put_byte(CH_BSLASH, 1'b0, 1'b1);
        put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else if (pick < 15) begin
        case ($urandom_range(0, 2))
          0: put_byte(CH_NUL, 1'b0, 1'b1);
          1: put_byte(CH_CR, 1'b0, 1'b1);
          default: put_byte(CH_LF, 1'b0, 1'b1);
        endcase
        return;
      end else begin
        do c = 8'($urandom_range(1, 255));
        while (c inside {CH_CR, CH_LF, CH_DQUOTE, CH_BSLASH});
        put_byte(c, 1'b0, 1'b1);
      end
    end
    if ($urandom_range(0, 19) == 0) return;
    put_byte(CH_DQUOTE, 1'b0, 1'b1);
    put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_count(input logic [63:0] v);
    logic [7:0] digits[$];
    int zeros;
    zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    repeat (zeros) put_byte(CH_ZERO, 1'b0, 1'b1);
    foreach (digits[i]) put_byte(digits[i], 1'b0, 1'b1);
  endtask

  task automatic send_literal();
    logic [63:0] count;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) count = $urandom_range(0, 6);
    else if (pick < 85) count = $urandom_range(7, 40);
    else if (pick < 90) count = {COUNT_WIDTH{1'b1}};
    else if (pick < 95) count = 64'h1_0000_0000 + $urandom;
    else count = {$urandom, $urandom};
    put_byte(CH_LBRACE, 1'b1, 1'b1);
    send_count(count);
    put_byte(CH_RBRACE, 1'b0, 1'b1);
    put_byte(CH_CR, 1'b0, 1'b1);
    put_byte(CH_LF, 1'b0, 1'b1);
    // Huge counts are only started; the next astring cuts them short.
    if (count > 40) begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      repeat (int'(count)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic send_bad_header();
    logic [7:0] c;
    put_byte(CH_LBRACE, 1'b1, 1'b1);
    case ($urandom_range(0, 3))
      0: put_byte(CH_RBRACE, 1'b0, 1'b1);
      1: begin
        do c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_RBRACE);
        put_byte(c, 1'b0, 1'b1);
      end
      2: begin
        put_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b1);
        put_byte(CH_RBRACE, 1'b0, 1'b1);
        put_byte(any_byte_except(CH_CR), 1'b0, 1'b1);
      end
      default: begin
        put_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b1);
        put_byte(CH_RBRACE, 1'b0, 1'b1);
        put_byte(CH_CR, 1'b0, 1'b1);
        put_byte(any_byte_except(CH_LF), 1'b0, 1'b1);
      end
    endcase
  endtask

  // Bad or instantly ended first bytes, followed by bytes the idle parser ignores.
  task automatic send_noise();
    case ($urandom_range(0, 8))
      0: put_byte(CH_NUL, 1'b1, 1'b1);
      1: put_byte(CH_SPACE, 1'b1, 1'b1);
      2: put_byte(CH_LPAREN, 1'b1, 1'b1);
      3: put_byte(CH_RPAREN, 1'b1, 1'b1);
      4: put_byte(CH_CR, 1'b1, 1'b1);
      5: put_byte(CH_LF, 1'b1, 1'b1);
      6: put_byte(CH_TAB, 1'b1, 1'b1);
      7: put_byte(CH_VT, 1'b1, 1'b1);
      default: put_byte(CH_FF, 1'b1, 1'b1);
    endcase
    repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic send_random_until(input int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) send_atom();
      else if (pick < 55) send_quoted();
      else if (pick < 85) send_literal();
      else if (pick < 93) send_bad_header();
      else send_noise();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Bad first bytes, then a byte that the idle parser ignores.
    put_byte(CH_NUL, 1'b1, 1'b1);
    put_byte(CH_SPACE, 1'b1, 1'b1);
    put_byte(CH_LPAREN, 1'b1, 1'b1);
    put_byte(CH_RPAREN, 1'b1, 1'b1);
    put_byte(CH_CR, 1'b1, 1'b1);
    put_byte(CH_LF, 1'b1, 1'b1);
    put_byte(8'hFF, 1'b0, 1'b0);
    // An empty atom ended at once by a tab.
    put_byte(CH_TAB, 1'b1, 1'b1);
    // An atom of high bytes ended by a closing paren.
    put_byte(8'hFF, 1'b1, 1'b1);
    put_byte(8'h80, 1'b0, 1'b1);
    put_byte(CH_RPAREN, 1'b0, 1'b1);
    // A quoted string holding an escaped quote, with NUL as the stop byte.
    put_byte(CH_DQUOTE, 1'b1, 1'b1);
    put_byte(CH_BSLASH, 1'b0, 1'b1);
    put_byte(CH_DQUOTE, 1'b0, 1'b1);
    put_byte(CH_DQUOTE, 1'b0, 1'b1);
    put_byte(CH_NUL, 1'b0, 1'b1);
    // A quoted string broken by a line feed.
    put_byte(CH_DQUOTE, 1'b1, 1'b1);
    put_byte(CH_LF, 1'b0, 1'b1);
    // An empty literal goes straight to its stop byte.
    put_byte(CH_LBRACE, 1'b1, 1'b1);
    put_byte(CH_ZERO, 1'b0, 1'b1);
    put_byte(CH_RBRACE, 1'b0, 1'b1);
    put_byte(CH_CR, 1'b0, 1'b1);
    put_byte(CH_LF, 1'b0, 1'b1);
    put_byte(8'h78, 1'b0, 1'b1);
    // A literal header with no digit.
    put_byte(CH_LBRACE, 1'b1, 1'b1);
    put_byte(CH_RBRACE, 1'b0, 1'b1);

    // The receiver holds off while items keep coming, so the input stalls.
    holds_asked = holds_asked + 1;
    send_random_until(600);
    drain_results();

    send_idle_pct = 72;
    recv_idle_pct = 11;
    holds_asked = holds_asked + 1;
    send_random_until(1200);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_until(ITEM_TARGET);
    drain_results();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
